// ===== rtl/core/dcpf_pkg.sv =====
// ---------------------------------------------------------------------------
// dcpf_pkg
// Shared constants, types and CRC helpers for the duty command packet framer.
// ---------------------------------------------------------------------------
package dcpf_pkg;

    localparam int IN_W    = 21;
    localparam int DUTY_W  = 18;
    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int CFG_W   = 8;
    localparam int IDX_W   = 2;
    localparam int POS_W   = 5;
    localparam int FRAME_W = 176;

    localparam logic signed [IN_W-1:0]   IN_POS_FULL   = 21'sd100000;
    localparam logic signed [IN_W-1:0]   IN_NEG_FULL   = -21'sd100000;
    localparam logic signed [DUTY_W-1:0] DUTY_POS_FULL = 18'sd100000;
    localparam logic signed [DUTY_W-1:0] DUTY_NEG_FULL = -18'sd100000;

    localparam logic [BYTE_W-1:0] FRAME_START = 8'h02;
    localparam logic [BYTE_W-1:0] FRAME_END   = 8'h03;
    localparam logic [BYTE_W-1:0] OP_SET_DUTY = 8'd5;
    localparam logic [BYTE_W-1:0] OP_FORWARD  = 8'd34;
    localparam logic [BYTE_W-1:0] LEN_SINGLE  = 8'd5;
    localparam logic [BYTE_W-1:0] LEN_FORWARD = 8'd7;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

    localparam logic [POS_W-1:0] POS_LAST_SINGLE = 5'd9;
    localparam logic [POS_W-1:0] POS_LAST_DUAL   = 5'd21;
    localparam logic [POS_W-1:0] POS_SECOND      = 5'd10;

    localparam logic [IDX_W-1:0] CFG_DUAL_ENABLE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SECOND_BUS_ID = 2'd1;
    localparam logic [IDX_W-1:0] CFG_INVERT_SECOND = 2'd2;

    localparam logic [BYTE_W-1:0] BUS_ID_RESET = 8'd25;

    typedef struct packed {
        logic              dual;
        logic              invert;
        logic [BYTE_W-1:0] bus_id;
    } t_cfg;

    function automatic logic signed [DUTY_W-1:0] sat_duty(
        input logic signed [IN_W-1:0] d
    );
        logic signed [DUTY_W-1:0] r;
        if (d > IN_POS_FULL) begin
            r = DUTY_POS_FULL;
        end else if (d < IN_NEG_FULL) begin
            r = DUTY_NEG_FULL;
        end else begin
            r = d[DUTY_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] duty_word(input logic signed [DUTY_W-1:0] d);
        return {{(WORD_W-DUTY_W){d[DUTY_W-1]}}, d};
    endfunction

    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((c & CRC_TOP) != '0) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/duty_command_packet_framer.sv =====
// ---------------------------------------------------------------------------
// duty_command_packet_framer
// Saturates a duty command and streams one or two CRC16 framed packets.
// ---------------------------------------------------------------------------
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | i_valid, o_ready, i_duty_scaled              | sink
//  out     | o_valid, i_ready, o_out_byte, o_packet_index, | source
//          | o_last                                       |
//  cfg     | i_cfg_we, i_cfg_idx, i_cfg_data              | write only
//
//  Five register stages: saturate, negate, CRC first half, CRC second half,
//  byte serializer, then the output register. The serializer sends one
//  byte per cycle while the output is not stalled. A word gives 10 bytes
//  (single) or 22 bytes (dual); the next word loads as the last byte goes.
//  Reset clears all valid bits and loads the register defaults.
//  An output stall backs up the full stages; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module duty_command_packet_framer
    import dcpf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [IN_W-1:0]   i_duty_scaled,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [BYTE_W-1:0]        o_out_byte,
    output logic                     o_packet_index,
    output logic                     o_last,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_cfg r_cfg;

    logic                     r_s1_valid;
    t_cfg                     r_s1_cfg;
    logic signed [DUTY_W-1:0] r_s1_duty;

    logic                     r_s2_valid;
    t_cfg                     r_s2_cfg;
    logic [WORD_W-1:0]        r_s2_wa;
    logic [WORD_W-1:0]        r_s2_wb;

    logic                     r_s3_valid;
    t_cfg                     r_s3_cfg;
    logic [WORD_W-1:0]        r_s3_wa;
    logic [WORD_W-1:0]        r_s3_wb;
    logic [CRC_W-1:0]         r_s3_crca;
    logic [CRC_W-1:0]         r_s3_crcb;

    logic                     r_s4_valid;
    logic                     r_s4_dual;
    logic [FRAME_W-1:0]       r_s4_frame;

    logic                     r_s5_valid;
    logic                     r_s5_dual;
    logic [POS_W-1:0]         r_s5_pos;
    logic [FRAME_W-1:0]       r_s5_sh;

    logic                     r_o_valid;
    logic [BYTE_W-1:0]        r_o_byte;
    logic                     r_o_pkt;
    logic                     r_o_last;

    logic o_free, s5_last, s5_send;
    logic s4_ready, s3_ready, s2_ready, s1_ready;
    logic [CRC_W-1:0] n_crca, n_crcb, n_crca_part, n_crcb_part;

    assign o_free   = !r_o_valid || i_ready;
    assign s5_last  = r_s5_pos == (r_s5_dual ? POS_LAST_DUAL : POS_LAST_SINGLE);
    assign s5_send  = r_s5_valid && o_free;
    assign s4_ready = !r_s5_valid || (o_free && s5_last);
    assign s3_ready = !r_s4_valid || s4_ready;
    assign s2_ready = !r_s3_valid || s3_ready;
    assign s1_ready = !r_s2_valid || s2_ready;
    assign o_ready  = !r_s1_valid || s1_ready;

    always_comb begin
        n_crca_part = crc_byte(crc_byte(crc_byte('0, OP_SET_DUTY),
                      r_s2_wa[31:24]), r_s2_wa[23:16]);
        n_crcb_part = crc_byte(crc_byte(crc_byte('0, OP_FORWARD),
                      r_s2_cfg.bus_id), OP_SET_DUTY);
        n_crca = crc_byte(crc_byte(r_s3_crca, r_s3_wa[15:8]), r_s3_wa[7:0]);
        n_crcb = crc_byte(crc_byte(crc_byte(crc_byte(r_s3_crcb, r_s3_wb[31:24]),
                 r_s3_wb[23:16]), r_s3_wb[15:8]), r_s3_wb[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dual   <= 1'b1;
            r_cfg.invert <= 1'b0;
            r_cfg.bus_id <= BUS_ID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DUAL_ENABLE:   r_cfg.dual   <= i_cfg_data[0];
                CFG_SECOND_BUS_ID: r_cfg.bus_id <= i_cfg_data;
                CFG_INVERT_SECOND: r_cfg.invert <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_ready)  r_s1_valid <= i_valid;
            if (s1_ready) r_s2_valid <= r_s1_valid;
            if (s2_ready) r_s3_valid <= r_s2_valid;
            if (s3_ready) r_s4_valid <= r_s3_valid;
            if (s4_ready) r_s5_valid <= r_s4_valid;
            if (o_free)   r_o_valid  <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_cfg  <= r_cfg;
            r_s1_duty <= sat_duty(i_duty_scaled);
        end
        if (s1_ready && r_s1_valid) begin
            r_s2_cfg <= r_s1_cfg;
            r_s2_wa  <= duty_word(r_s1_duty);
            r_s2_wb  <= duty_word(r_s1_cfg.invert ? -r_s1_duty : r_s1_duty);
        end
        if (s2_ready && r_s2_valid) begin
            r_s3_cfg  <= r_s2_cfg;
            r_s3_wa   <= r_s2_wa;
            r_s3_wb   <= r_s2_wb;
            r_s3_crca <= n_crca_part;
            r_s3_crcb <= n_crcb_part;
        end
        if (s3_ready && r_s3_valid) begin
            r_s4_dual  <= r_s3_cfg.dual;
            r_s4_frame <= {FRAME_START, LEN_SINGLE, OP_SET_DUTY, r_s3_wa, n_crca, FRAME_END,
                           FRAME_START, LEN_FORWARD, OP_FORWARD, r_s3_cfg.bus_id,
                           OP_SET_DUTY, r_s3_wb, n_crcb, FRAME_END};
        end
        // load a new frame, or advance one byte
        if (s4_ready && r_s4_valid) begin
            r_s5_dual <= r_s4_dual;
            r_s5_pos  <= '0;
            r_s5_sh   <= r_s4_frame;
        end else if (s5_send) begin
            r_s5_pos  <= r_s5_pos + 1'b1;
            r_s5_sh   <= {r_s5_sh[FRAME_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
        end
        if (s5_send) begin
            r_o_byte <= r_s5_sh[FRAME_W-1 -: BYTE_W];
            r_o_pkt  <= r_s5_pos >= POS_SECOND;
            r_o_last <= s5_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_packet_index = r_o_pkt;
    assign o_last         = r_o_last;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s5_valid |-> r_s5_pos <= (r_s5_dual ? POS_LAST_DUAL : POS_LAST_SINGLE))
        else $error("serializer position past end of frame");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_valid && r_s5_pos == '0) |-> r_s5_sh[FRAME_W-1 -: BYTE_W] == FRAME_START)
        else $error("frame does not open with start byte");

    a_next_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (!o_valid || o_out_byte == FRAME_START))
        else $error("word after last is not a start byte");

    a_last_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_valid && s5_last) |-> (r_s5_pos >= POS_SECOND) == r_s5_dual)
        else $error("last byte in wrong packet");

endmodule

// ===== dv/dcpf_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// dcpf_tb_pkg
// Byte stream predictor and checker for the duty command packet framer:
// builds the expected framed bytes of every accepted duty command and
// compares each accepted output word against them in order.
// ---------------------------------------------------------------------------
package dcpf_tb_pkg;

    import dcpf_pkg::*;

    class duty_frame_scoreboard;

        typedef struct {
            logic [BYTE_W-1:0] data;
            logic              pkt;
            logic              last;
        } t_frame_byte;

        localparam int DUTY_LIMIT = 100000;

        t_frame_byte expected_bytes[$];
        t_cfg        regs;
        int unsigned mismatches;
        int unsigned bytes_seen;

        function new();
            regs.dual   = 1'b1;
            regs.invert = 1'b0;
            regs.bus_id = BUS_ID_RESET;
            mismatches  = 0;
            bytes_seen  = 0;
        endfunction

        function void set_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                CFG_DUAL_ENABLE:   regs.dual   = data[0];
                CFG_SECOND_BUS_ID: regs.bus_id = data;
                CFG_INVERT_SECOND: regs.invert = data[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void push_frame(input logic [55:0] pay, input int len,
                                 input logic pkt, input logic ends);
            logic [CRC_W-1:0]  crc;
            logic [BYTE_W-1:0] b;
            crc = '0;
            expected_bytes.push_back(t_frame_byte'{FRAME_START, pkt, 1'b0});
            expected_bytes.push_back(t_frame_byte'{BYTE_W'(len), pkt, 1'b0});
            for (int k = 0; k < len; k++) begin
                b = pay[8*(len-1-k) +: 8];
                expected_bytes.push_back(t_frame_byte'{b, pkt, 1'b0});
                crc = crc ^ {b, 8'h00};
                for (int j = 0; j < 8; j++) begin
                    if ((crc & CRC_TOP) != '0) begin
                        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
                    end else begin
                        crc = {crc[CRC_W-2:0], 1'b0};
                    end
                end
            end
            expected_bytes.push_back(t_frame_byte'{crc[15:8], pkt, 1'b0});
            expected_bytes.push_back(t_frame_byte'{crc[7:0], pkt, 1'b0});
            expected_bytes.push_back(t_frame_byte'{FRAME_END, pkt, ends});
        endfunction

        function void note_command(input logic signed [IN_W-1:0] duty);
            int          level;
            logic [31:0] word_a;
            logic [31:0] word_b;
            level = duty;
            if (level > DUTY_LIMIT) begin
                level = DUTY_LIMIT;
            end else if (level < -DUTY_LIMIT) begin
                level = -DUTY_LIMIT;
            end
            word_a = level;
            push_frame({16'h0000, OP_SET_DUTY, word_a}, 5, 1'b0, !regs.dual);
            if (regs.dual) begin
                word_b = regs.invert ? -level : level;
                push_frame({OP_FORWARD, regs.bus_id, OP_SET_DUTY, word_b}, 7, 1'b1, 1'b1);
            end
        endfunction

        task report_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_byte(input logic [BYTE_W-1:0] data, input logic pkt, input logic last);
            t_frame_byte want;
            bytes_seen++;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("byte %0d = %h arrived with none due",
                                          bytes_seen, data));
            end else begin
                want = expected_bytes.pop_front();
                if (data !== want.data || pkt !== want.pkt || last !== want.last) begin
                    report_mismatch($sformatf(
                        "byte %0d got data %h pkt %b last %b, want %h %b %b",
                        bytes_seen, data, pkt, last, want.data, want.pkt, want.last));
                end
            end
        endtask

        task check_drained();
            if (expected_bytes.size() != 0) begin
                report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
            end
        endtask

    endclass

endpackage

// ===== dv/duty_command_packet_framer_tb.sv =====
// ---------------------------------------------------------------------------
// duty_command_packet_framer_tb
// Drives duty commands through the framer under several register settings,
// with random gaps and output stalls, and checks every output word against
// the predicted framed byte stream.
// ---------------------------------------------------------------------------
module duty_command_packet_framer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dcpf_pkg::*;
    import dcpf_tb_pkg::*;

    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int STALL_LIMIT      = 2000;
    localparam int HOLD_CYCLES      = 150;
    localparam int RANDOM_PER_PHASE = 20;
    localparam int TAIL_CYCLES      = 8;
    localparam int EDGE_COUNT       = 10;

    localparam logic signed [IN_W-1:0] EDGE_DUTIES [EDGE_COUNT] = '{
        21'sd0, -21'sd1, 21'sd100000, 21'sd100001, -21'sd100000, -21'sd100001,
        21'sd1048575, -21'sd1048576, 21'h0AAAAA, 21'h155555
    };

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic                   o_ready;
    logic signed [IN_W-1:0] i_duty_scaled  = '0;
    logic                   o_valid;
    logic                   i_ready        = 1'b0;
    logic [BYTE_W-1:0]      o_out_byte;
    logic                   o_packet_index;
    logic                   o_last;
    logic                   i_cfg_we       = 1'b0;
    logic [IDX_W-1:0]       i_cfg_idx      = '0;
    logic [CFG_W-1:0]       i_cfg_data     = '0;

    bit calm        = 1'b0;
    bit hold_output = 1'b0;

    duty_frame_scoreboard board = new();

    duty_command_packet_framer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_duty_scaled  (i_duty_scaled),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_packet_index (o_packet_index),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            board.note_command(i_duty_scaled);
        end
        if (i_rst_n && o_valid && i_ready) begin
            board.check_byte(o_out_byte, o_packet_index, o_last);
        end
    end

    // hold off the output for a long stretch when asked
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_output) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end
            i_ready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [IN_W-1:0] random_duty();
        int unsigned pick;
        logic signed [IN_W-1:0] v;
        pick = $urandom_range(0, 9);
        v = IN_W'($urandom);
        if (pick < 4) begin
            v = IN_W'(int'($urandom_range(0, 200000)) - 100000);
        end else if (pick < 6) begin
            v = IN_W'((pick == 4 ? 100000 : -100000) + int'($urandom_range(0, 4)) - 2);
        end
        return v;
    endfunction

    task automatic send_command(input logic signed [IN_W-1:0] duty);
        while (!calm && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_duty_scaled <= duty;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_for_frames();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_register(idx, data);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] dual_raw,
                                  input logic [CFG_W-1:0] id_raw,
                                  input logic [CFG_W-1:0] inv_raw);
        write_reg(CFG_UNUSED, CFG_W'($urandom));
        write_reg(CFG_DUAL_ENABLE, dual_raw);
        write_reg(CFG_SECOND_BUS_ID, id_raw);
        write_reg(CFG_INVERT_SECOND, inv_raw);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < EDGE_COUNT; k++) begin
            send_command(EDGE_DUTIES[k]);
        end

        wait_for_frames();
        apply_settings(8'hFE, 8'h00, 8'hFE);
        for (int k = 2; k < 8; k++) begin
            send_command(EDGE_DUTIES[k]);
        end

        wait_for_frames();
        apply_settings(8'hFF, 8'hFF, 8'h01);
        for (int k = 2; k < 8; k++) begin
            send_command(EDGE_DUTIES[k]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            wait_for_frames();
            case (phase)
                0:       apply_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
                1:       apply_settings(8'h00, CFG_W'($urandom), 8'h01);
                2:       apply_settings(8'h01, 8'hFF, 8'h01);
                default: apply_settings(8'h01, 8'h00, CFG_W'($urandom));
            endcase
            calm        = (phase == 1);
            hold_output = (phase == 2);
            repeat (RANDOM_PER_PHASE) send_command(random_duty());
        end
        calm = 1'b0;

        wait_for_frames();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        board.check_drained();
        if (board.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
